FILE: rtl/core/rstab_pkg.sv
// Shared constants, request codes and the cell-to-cell chain type for the
// reservation station table. No dependencies.
`timescale 1ns / 1ps

package rstab_pkg;

  localparam int ENTRIES_DEF   = 8;
  localparam int TAG_BITS_DEF  = 6;
  localparam int DATA_BITS_DEF = 32;

  localparam int OP_BITS   = 3;
  localparam int CFG_BITS  = 4;
  localparam int CYC_BITS  = 8;
  localparam int KIND_BITS = 3;
  localparam int CODE_BITS = 6;

  localparam logic [CFG_BITS-1:0]  CFG_RESET = 4'd8;
  localparam logic [KIND_BITS-1:0] KIND_ALU  = 3'd0;

  typedef enum logic [OP_BITS-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FILL   = 3'd1,
    OP_WAKEUP = 3'd2,
    OP_TICK   = 3'd3,
    OP_FREE   = 3'd4,
    OP_FLUSH  = 3'd5,
    OP_FIND   = 3'd6,
    OP_READ   = 3'd7
  } rstab_op_t;

  typedef struct packed {
    logic taken;
    logic hit;
    logic all_busy;
  } rstab_chain_t;

endpackage

FILE: rtl/core/rstab_cell.sv
// One table slot: holds an entry and passes the priority and full chain on.
// Depends on rstab_pkg.
`timescale 1ns / 1ps

module rstab_cell
  import rstab_pkg::*;
#(
  parameter int TAG_BITS  = TAG_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  rstab_op_t            op,
  input  logic                 active,
  input  logic                 sel,
  input  logic [TAG_BITS-1:0]  tag,
  input  logic [DATA_BITS-1:0] value,
  input  logic                 src1_wait,
  input  logic [TAG_BITS-1:0]  src1_tag,
  input  logic                 src2_wait,
  input  logic [TAG_BITS-1:0]  src2_tag,
  input  logic [DATA_BITS-1:0] src2_value,
  input  logic [CYC_BITS-1:0]  exec_cycles,
  input  logic [KIND_BITS-1:0] unit_kind,
  input  logic [CODE_BITS-1:0] instr_code,
  input  rstab_chain_t         chain_i,
  output rstab_chain_t         chain_o,
  output logic                 won,
  output logic                 busy_o,
  output logic                 ready_o,
  output logic [TAG_BITS-1:0]  dst_tag_o,
  output logic [CODE_BITS-1:0] instr_code_o,
  output logic [KIND_BITS-1:0] unit_kind_o,
  output logic [DATA_BITS-1:0] src1_value_o,
  output logic [DATA_BITS-1:0] src2_value_o,
  output logic [CYC_BITS-1:0]  cycles_o
);

  logic                 busy_r,  busy_nxt;
  logic [TAG_BITS-1:0]  dest_r,  dest_nxt;
  logic [CODE_BITS-1:0] code_r,  code_nxt;
  logic [KIND_BITS-1:0] kind_r,  kind_nxt;
  logic                 w1_r,    w1_nxt;
  logic [TAG_BITS-1:0]  t1_r,    t1_nxt;
  logic [DATA_BITS-1:0] v1_r,    v1_nxt;
  logic                 w2_r,    w2_nxt;
  logic [TAG_BITS-1:0]  t2_r,    t2_nxt;
  logic [DATA_BITS-1:0] v2_r,    v2_nxt;
  logic [CYC_BITS-1:0]  cyc_r,   cyc_nxt;

  logic live;
  logic free_here;
  logic match;

  assign live      = active && busy_r;
  assign free_here = active && !busy_r;
  assign match     = live && (dest_r == tag);

  assign won = ((op == OP_ALLOC) && free_here && !chain_i.taken) ||
               ((op == OP_FIND) && match && !chain_i.hit);

  always_comb begin
    busy_nxt = busy_r;
    dest_nxt = dest_r;
    code_nxt = code_r;
    kind_nxt = kind_r;
    w1_nxt   = w1_r;
    t1_nxt   = t1_r;
    v1_nxt   = v1_r;
    w2_nxt   = w2_r;
    t2_nxt   = t2_r;
    v2_nxt   = v2_r;
    cyc_nxt  = cyc_r;
    if (go) begin
      case (op)
        OP_ALLOC: begin
          if (free_here && !chain_i.taken) begin
            busy_nxt = 1'b1;
            dest_nxt = tag;
            code_nxt = '0;
            kind_nxt = '0;
            w1_nxt   = 1'b0;
            t1_nxt   = '0;
            v1_nxt   = '0;
            w2_nxt   = 1'b0;
            t2_nxt   = '0;
            v2_nxt   = '0;
            cyc_nxt  = '0;
          end
        end
        OP_FILL: begin
          if (sel && live) begin
            w1_nxt   = src1_wait;
            t1_nxt   = src1_wait ? src1_tag : '0;
            v1_nxt   = src1_wait ? '0 : value;
            w2_nxt   = src2_wait;
            t2_nxt   = src2_wait ? src2_tag : '0;
            v2_nxt   = src2_wait ? '0 : src2_value;
            cyc_nxt  = exec_cycles;
            kind_nxt = unit_kind;
            code_nxt = instr_code;
          end
        end
        OP_WAKEUP: begin
          if (live && w1_r && (t1_r == tag)) begin
            v1_nxt = value;
            w1_nxt = 1'b0;
            t1_nxt = '0;
          end
          if (live && w2_r && (t2_r == tag)) begin
            v2_nxt = value;
            w2_nxt = 1'b0;
            t2_nxt = '0;
          end
        end
        OP_TICK: begin
          if (live && (kind_r == KIND_ALU) && (cyc_r != '0)) begin
            cyc_nxt = cyc_r - 1'b1;
          end
        end
        OP_FREE, OP_FLUSH: begin
          if ((op == OP_FREE && sel && active) || (op == OP_FLUSH && live && dest_r > tag)) begin
            busy_nxt = 1'b0;
            dest_nxt = '0;
            code_nxt = '0;
            kind_nxt = '0;
            w1_nxt   = 1'b0;
            t1_nxt   = '0;
            v1_nxt   = '0;
            w2_nxt   = 1'b0;
            t2_nxt   = '0;
            v2_nxt   = '0;
            cyc_nxt  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dest_r <= '0;
      code_r <= '0;
      kind_r <= '0;
      w1_r   <= 1'b0;
      t1_r   <= '0;
      v1_r   <= '0;
      w2_r   <= 1'b0;
      t2_r   <= '0;
      v2_r   <= '0;
      cyc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      dest_r <= dest_nxt;
      code_r <= code_nxt;
      kind_r <= kind_nxt;
      w1_r   <= w1_nxt;
      t1_r   <= t1_nxt;
      v1_r   <= v1_nxt;
      w2_r   <= w2_nxt;
      t2_r   <= t2_nxt;
      v2_r   <= v2_nxt;
      cyc_r  <= cyc_nxt;
    end
  end

  // pass priority and occupancy up the row
  assign chain_o.taken    = chain_i.taken || free_here;
  assign chain_o.hit      = chain_i.hit || match;
  assign chain_o.all_busy = chain_i.all_busy && (!active || busy_nxt);

  assign busy_o       = busy_r;
  assign ready_o      = busy_r && !w1_r && !w2_r;
  assign dst_tag_o    = dest_r;
  assign instr_code_o = code_r;
  assign unit_kind_o  = kind_r;
  assign src1_value_o = v1_r;
  assign src2_value_o = v2_r;
  assign cycles_o     = cyc_r;

endmodule

FILE: rtl/core/reservation_station_table.sv
// Top level of the reservation station table: a row of rstab_cell slots,
// the slot-count register and the registered result port. Depends on rstab_pkg.
//
//   channel   ports                     handshake
//   request   start/busy, in_*          taken when start && !busy
//   result    out_valid, out_*          one-cycle strobe, no back-pressure
//   config    cfg_valid/cfg_ready, cfg_data  written when cfg_valid && cfg_ready
//
// For every request, all slots act on it in parallel, the priority
// and full chain ripples through the row of cells, and the result appears on
// the cycle after acceptance. busy stays low, so a request may come every cycle.
// Synchronous reset clears every slot and sets the slot count to 8.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module reservation_station_table
  import rstab_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_BITS-1:0]   in_op,
  input  logic [SLOT_W-1:0]    in_slot_index,
  input  logic [TAG_BITS-1:0]  in_tag,
  input  logic [DATA_BITS-1:0] in_value,
  input  logic                 in_src1_wait,
  input  logic [TAG_BITS-1:0]  in_src1_tag,
  input  logic                 in_src2_wait,
  input  logic [TAG_BITS-1:0]  in_src2_tag,
  input  logic [DATA_BITS-1:0] in_src2_value,
  input  logic [CYC_BITS-1:0]  in_exec_cycles,
  input  logic [KIND_BITS-1:0] in_unit_kind,
  input  logic [CODE_BITS-1:0] in_instr_code,
  output logic                 out_valid,
  output logic                 out_ok,
  output logic [SLOT_W-1:0]    out_slot,
  output logic                 out_full_res,
  output logic                 out_busy_res,
  output logic                 out_ready_res,
  output logic [TAG_BITS-1:0]  out_dst_tag_out,
  output logic [CODE_BITS-1:0] out_instr_code_out,
  output logic [KIND_BITS-1:0] out_unit_kind_out,
  output logic [DATA_BITS-1:0] out_src1_value_out,
  output logic [DATA_BITS-1:0] out_src2_value_out,
  output logic [CYC_BITS-1:0]  out_cycles_left,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_BITS-1:0]  cfg_data
);

  logic [CFG_BITS-1:0] cfg_r;
  logic                go;
  rstab_op_t           op;

  rstab_chain_t        chain [ENTRIES+1];
  logic [ENTRIES-1:0]  act;
  logic [ENTRIES-1:0]  sel;
  logic [ENTRIES-1:0]  won;
  logic [ENTRIES-1:0]  v_busy;
  logic [ENTRIES-1:0]  v_ready;
  logic [TAG_BITS-1:0]  v_dest [ENTRIES];
  logic [CODE_BITS-1:0] v_code [ENTRIES];
  logic [KIND_BITS-1:0] v_kind [ENTRIES];
  logic [DATA_BITS-1:0] v_src1 [ENTRIES];
  logic [DATA_BITS-1:0] v_src2 [ENTRIES];
  logic [CYC_BITS-1:0]  v_cyc  [ENTRIES];

  logic                 ok_nxt;
  logic [SLOT_W-1:0]    slot_nxt;
  logic                 rd_busy, rd_ready;
  logic [TAG_BITS-1:0]  rd_dest;
  logic [CODE_BITS-1:0] rd_code;
  logic [KIND_BITS-1:0] rd_kind;
  logic [DATA_BITS-1:0] rd_src1, rd_src2;
  logic [CYC_BITS-1:0]  rd_cyc;
  logic [SLOT_W-1:0]    win_slot;
  logic                 idx_ok;
  logic                 idx_busy;

  logic                 out_valid_r;
  logic                 ok_r;
  logic [SLOT_W-1:0]    slot_r;
  logic                 full_r;
  logic                 rbusy_r, rready_r;
  logic [TAG_BITS-1:0]  rdest_r;
  logic [CODE_BITS-1:0] rcode_r;
  logic [KIND_BITS-1:0] rkind_r;
  logic [DATA_BITS-1:0] rsrc1_r, rsrc2_r;
  logic [CYC_BITS-1:0]  rcyc_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign go        = start && !busy;
  assign op        = rstab_op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  assign chain[0].taken    = 1'b0;
  assign chain[0].hit      = 1'b0;
  assign chain[0].all_busy = 1'b1;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign act[i] = (i == 0) || (32'(cfg_r) > i);
    assign sel[i] = (32'(in_slot_index) == i);

    rstab_cell #(
      .TAG_BITS  (TAG_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .go           (go),
      .op           (op),
      .active       (act[i]),
      .sel          (sel[i]),
      .tag          (in_tag),
      .value        (in_value),
      .src1_wait    (in_src1_wait),
      .src1_tag     (in_src1_tag),
      .src2_wait    (in_src2_wait),
      .src2_tag     (in_src2_tag),
      .src2_value   (in_src2_value),
      .exec_cycles  (in_exec_cycles),
      .unit_kind    (in_unit_kind),
      .instr_code   (in_instr_code),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .won          (won[i]),
      .busy_o       (v_busy[i]),
      .ready_o      (v_ready[i]),
      .dst_tag_o    (v_dest[i]),
      .instr_code_o (v_code[i]),
      .unit_kind_o  (v_kind[i]),
      .src1_value_o (v_src1[i]),
      .src2_value_o (v_src2[i]),
      .cycles_o     (v_cyc[i])
    );
  end

  // gather the addressed slot and the winning slot
  always_comb begin
    idx_ok   = 1'b0;
    idx_busy = 1'b0;
    rd_busy  = 1'b0;
    rd_ready = 1'b0;
    rd_dest  = '0;
    rd_code  = '0;
    rd_kind  = '0;
    rd_src1  = '0;
    rd_src2  = '0;
    rd_cyc   = '0;
    win_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i] && act[i]) begin
        idx_ok   = 1'b1;
        idx_busy = v_busy[i];
        rd_busy  = v_busy[i];
        rd_ready = v_ready[i];
        rd_dest  = v_dest[i];
        rd_code  = v_code[i];
        rd_kind  = v_kind[i];
        rd_src1  = v_src1[i];
        rd_src2  = v_src2[i];
        rd_cyc   = v_cyc[i];
      end
      if (won[i]) begin
        win_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ok_nxt   = 1'b0;
    slot_nxt = '0;
    case (op)
      OP_ALLOC: begin
        ok_nxt   = chain[ENTRIES].taken;
        slot_nxt = win_slot;
      end
      OP_FIND: begin
        ok_nxt   = chain[ENTRIES].hit;
        slot_nxt = win_slot;
      end
      OP_FILL: begin
        ok_nxt   = idx_ok && idx_busy;
        slot_nxt = in_slot_index;
      end
      OP_FREE, OP_READ: begin
        ok_nxt   = idx_ok;
        slot_nxt = in_slot_index;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ok_r     <= ok_nxt;
      slot_r   <= slot_nxt;
      full_r   <= chain[ENTRIES].all_busy;
      rbusy_r  <= (op == OP_READ) && rd_busy;
      rready_r <= (op == OP_READ) && rd_ready;
      rdest_r  <= (op == OP_READ) ? rd_dest : '0;
      rcode_r  <= (op == OP_READ) ? rd_code : '0;
      rkind_r  <= (op == OP_READ) ? rd_kind : '0;
      rsrc1_r  <= (op == OP_READ) ? rd_src1 : '0;
      rsrc2_r  <= (op == OP_READ) ? rd_src2 : '0;
      rcyc_r   <= (op == OP_READ) ? rd_cyc  : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = ok_r;
  assign out_slot           = slot_r;
  assign out_full_res       = full_r;
  assign out_busy_res       = rbusy_r;
  assign out_ready_res      = rready_r;
  assign out_dst_tag_out    = rdest_r;
  assign out_instr_code_out = rcode_r;
  assign out_unit_kind_out  = rkind_r;
  assign out_src1_value_out = rsrc1_r;
  assign out_src2_value_out = rsrc2_r;
  assign out_cycles_left    = rcyc_r;

  a_one_winner: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(won))
    else $error("more than one slot claimed a request");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("accepted request produced no result");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (go && op == OP_ALLOC && chain[ENTRIES].taken) |=> v_busy[slot_r])
    else $error("allocated slot not marked busy");

  a_full_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && full_r) |-> v_busy[0])
    else $error("full reported with slot 0 free");

endmodule
